// File: rtl/two_pulse_channel_sound_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef TWO_PULSE_CHANNEL_SOUND_UNIT_ASSERT_SVH
`define TWO_PULSE_CHANNEL_SOUND_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TPCSU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TPCSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tpcsu_pkg.sv
`timescale 1ns / 1ps

package tpcsu_pkg;

   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 16;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned PERIOD_W   = 24;
   localparam int unsigned ACC_W      = 25;
   localparam int unsigned TIMER_W    = 11;
   localparam int unsigned INDEX_W    = 10;

   // Request kinds carried on req_tuser
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // Bus register map
   localparam logic [15:0] ADDR_DUTY0   = 16'h4000;
   localparam logic [15:0] ADDR_TLO0    = 16'h4002;
   localparam logic [15:0] ADDR_THI0    = 16'h4003;
   localparam logic [15:0] ADDR_DUTY1   = 16'h4004;
   localparam logic [15:0] ADDR_TLO1    = 16'h4006;
   localparam logic [15:0] ADDR_THI1    = 16'h4007;
   localparam logic [15:0] ADDR_ENABLE  = 16'h4015;

   // CSR register index
   localparam logic CSR_SAMPLE_PERIOD = 1'b0;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd7346831;
   localparam logic [ACC_W-1:0]    ACC_ONE      = 25'h0010000;
   localparam logic [2:0]          PRESCALE_TOP = 3'd6;

   typedef struct packed {
      logic [INDEX_W-1:0] sample_index;
      logic [1:0]         sample_level;
   } rsp_item_type;

   function automatic logic [7:0] duty_lookup(input logic [1:0] sel);
      logic [7:0] pat;
      case (sel)
         2'd0:    pat = 8'b0000_0001;
         2'd1:    pat = 8'b0000_0011;
         2'd2:    pat = 8'b0000_1111;
         2'd3:    pat = 8'b1111_1100;
         default: pat = 8'b0000_0001;
      endcase
      return pat;
   endfunction

endpackage

// File: rtl/two_pulse_channel_sound_unit.sv
`timescale 1ns / 1ps
// A tick that yields a sample is registered into the output buffer, whose head entry drives rsp.
// One item per cycle while req_tready is high; all channel and decimator state updates in the
//   accepting cycle, so ticks and bus writes may arrive back to back.
// A two-entry output buffer drops req_tready only while both entries hold samples.
// Reset (synchronous, active high) clears all channel state, the accumulator,
//   the buffer position and the output buffer, and loads the default sample period.
module two_pulse_channel_sound_unit #(
   parameter int unsigned WAVE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tpcsu_pkg::REQ_DATA_W-1:0]    req_tdata,   // [15:0] address, [23:16] write_value
   input  logic                                req_tuser,   // [0] req_type
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tpcsu_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [1:0] sample_level, [11:2] sample_index, [15:12] zero
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tpcsu_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [tpcsu_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [tpcsu_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   // Buffer position counter width follows the buffer depth.
   localparam int unsigned POS_W = (WAVE_DEPTH > 1) ? $clog2(WAVE_DEPTH) : 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(WAVE_DEPTH - 1);

   // ---------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------
   logic [tpcsu_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic                           csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      period_in = period_ff;
      if (csr_wr && (csr_paddr[2] == tpcsu_pkg::CSR_SAMPLE_PERIOD)) begin
         period_in = csr_pwdata[tpcsu_pkg::PERIOD_W-1:0];
      end
   end

   // Addresses with bit 2 clear read back the period; addresses with bit 2 set read zero.
   assign csr_prdata = (csr_paddr[2] == tpcsu_pkg::CSR_SAMPLE_PERIOD)
                       ? tpcsu_pkg::CSR_DATA_W'(period_ff) : '0;

   // ---------------------------------------------------------------------
   // Input decode
   // ---------------------------------------------------------------------
   logic        accept;
   logic        is_tick;
   logic        is_write;
   logic [15:0] address;
   logic [7:0]  write_value;

   assign accept      = req_tvalid & req_tready;
   assign is_tick     = accept & (req_tuser == tpcsu_pkg::REQ_TICK);
   assign is_write    = accept & (req_tuser == tpcsu_pkg::REQ_WRITE);
   assign address     = req_tdata[15:0];
   assign write_value = req_tdata[23:16];

   // ---------------------------------------------------------------------
   // Channel and decimator state
   // ---------------------------------------------------------------------
   logic [2:0]                        prescale_ff, prescale_in;
   logic [1:0]                        enable_ff, enable_in;
   logic [7:0]                        duty_ff [2];
   logic [7:0]                        duty_in [2];
   logic [tpcsu_pkg::TIMER_W-1:0]     reload_ff [2];
   logic [tpcsu_pkg::TIMER_W-1:0]     reload_in [2];
   logic [tpcsu_pkg::TIMER_W-1:0]     timer_ff [2];
   logic [tpcsu_pkg::TIMER_W-1:0]     timer_in [2];
   logic [1:0]                        chan_out_ff, chan_out_in;
   logic [tpcsu_pkg::ACC_W-1:0]       acc_ff, acc_in;
   logic [POS_W-1:0]                  pos_ff, pos_in;

   logic [2:0]                        prescale_inc;
   logic                              chan_step;
   logic [tpcsu_pkg::ACC_W-1:0]       acc_sub;
   logic                              emit;
   tpcsu_pkg::rsp_item_type           new_item;

   assign prescale_inc = prescale_ff + 3'd1;
   // Every sixth tick clocks the channel timers.
   assign chan_step    = is_tick & (prescale_inc >= tpcsu_pkg::PRESCALE_TOP);

   // Decimator: drop one tick's worth, emit when at or below zero.
   assign acc_sub = acc_ff - tpcsu_pkg::ACC_ONE;
   assign emit    = is_tick & ((acc_sub == '0) | acc_sub[tpcsu_pkg::ACC_W-1]);

   always_comb begin
      prescale_in = prescale_ff;
      enable_in   = enable_ff;
      chan_out_in = chan_out_ff;
      acc_in      = acc_ff;
      pos_in      = pos_ff;
      for (int ch = 0; ch < 2; ch++) begin
         duty_in[ch]   = duty_ff[ch];
         reload_in[ch] = reload_ff[ch];
         timer_in[ch]  = timer_ff[ch];
      end

      // Bus writes from the request stream
      if (is_write) begin
         case (address)
            tpcsu_pkg::ADDR_DUTY0:  duty_in[0] = tpcsu_pkg::duty_lookup(write_value[7:6]);
            tpcsu_pkg::ADDR_DUTY1:  duty_in[1] = tpcsu_pkg::duty_lookup(write_value[7:6]);
            tpcsu_pkg::ADDR_TLO0:   reload_in[0][7:0]  = write_value;
            tpcsu_pkg::ADDR_TLO1:   reload_in[1][7:0]  = write_value;
            tpcsu_pkg::ADDR_THI0:   reload_in[0][10:8] = write_value[2:0];
            tpcsu_pkg::ADDR_THI1:   reload_in[1][10:8] = write_value[2:0];
            tpcsu_pkg::ADDR_ENABLE: enable_in = write_value[1:0];
            default: ;
         endcase
      end

      if (is_tick) begin
         prescale_in = chan_step ? 3'd0 : prescale_inc;
         acc_in      = emit ? (acc_sub + tpcsu_pkg::ACC_W'(period_ff)) : acc_sub;
         if (emit) begin
            pos_in = (pos_ff == POS_LAST) ? '0 : pos_ff + POS_W'(1);
         end
      end

      // Timer step: reload and rotate the duty pattern on underflow,
      // otherwise count down. A disabled channel holds and outputs zero.
      if (chan_step) begin
         for (int ch = 0; ch < 2; ch++) begin
            if (enable_ff[ch]) begin
               if (timer_ff[ch] == '0) begin
                  timer_in[ch]    = reload_ff[ch];
                  duty_in[ch]     = {duty_ff[ch][0], duty_ff[ch][7:1]};
                  chan_out_in[ch] = duty_ff[ch][1];
               end else begin
                  timer_in[ch] = timer_ff[ch] - tpcsu_pkg::TIMER_W'(1);
               end
            end else begin
               chan_out_in[ch] = 1'b0;
            end
         end
      end
   end

   // Sample uses the channel outputs after this tick's step.
   assign new_item.sample_level = {1'b0, chan_out_in[0]} + {1'b0, chan_out_in[1]};
   assign new_item.sample_index = tpcsu_pkg::INDEX_W'(pos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= tpcsu_pkg::PERIOD_RESET;
         prescale_ff <= '0;
         enable_ff   <= '0;
         chan_out_ff <= '0;
         acc_ff      <= '0;
         pos_ff      <= '0;
         for (int ch = 0; ch < 2; ch++) begin
            duty_ff[ch]   <= '0;
            reload_ff[ch] <= '0;
            timer_ff[ch]  <= '0;
         end
      end else begin
         period_ff   <= period_in;
         prescale_ff <= prescale_in;
         enable_ff   <= enable_in;
         chan_out_ff <= chan_out_in;
         acc_ff      <= acc_in;
         pos_ff      <= pos_in;
         for (int ch = 0; ch < 2; ch++) begin
            duty_ff[ch]   <= duty_in[ch];
            reload_ff[ch] <= reload_in[ch];
            timer_ff[ch]  <= timer_in[ch];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output buffer: head entry drives rsp, skid entry catches a sample
   // produced while the head is stalled.
   // ---------------------------------------------------------------------
   logic [1:0]              count_ff, count_in;
   tpcsu_pkg::rsp_item_type head_ff, head_in;
   tpcsu_pkg::rsp_item_type skid_ff, skid_in;
   logic                    pop;

   assign pop = rsp_tvalid & rsp_tready;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      skid_in  = skid_ff;
      case (count_ff)
         2'd0: begin
            if (emit) begin
               head_in  = new_item;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (pop && emit) begin
               head_in = new_item;
            end else if (pop) begin
               count_in = 2'd0;
            end else if (emit) begin
               skid_in  = new_item;
               count_in = 2'd2;
            end
         end
         2'd2: begin
            // Input is held off here, so only a pop can happen.
            if (pop) begin
               head_in  = skid_ff;
               count_in = 2'd1;
            end
         end
         default: count_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign req_tready = (count_ff != 2'd2);
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = tpcsu_pkg::RSP_DATA_W'(head_ff);

endmodule

// File: rtl/tpcsu_checker.sv
`timescale 1ns / 1ps
`include "two_pulse_channel_sound_unit_assert.svh"

module tpcsu_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tpcsu_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic write_only_idle;

   // A bus write accepted with nothing pending must leave the output empty.
   assign write_only_idle = req_tvalid & req_tready & (req_tuser == tpcsu_pkg::REQ_WRITE)
                            & ~rsp_tvalid;

   // hold a stalled sample
   `TPCSU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                      rsp_tvalid && $stable(rsp_tdata), "stalled sample changed")

   // level is the sum of two bits, never three
   `TPCSU_ASSERT_NOW(a_level_range, clock, reset, rsp_tvalid, rsp_tdata[1:0] != 2'd3,
                     "sample level out of range")

   // backpressure only comes from a full output buffer
   `TPCSU_ASSERT_NOW(a_stall_cause, clock, reset, !req_tready, rsp_tvalid,
                     "input stalled with no sample pending")

   `TPCSU_ASSERT_NEXT(a_write_silent, clock, reset, write_only_idle, !rsp_tvalid,
                      "bus write produced a sample")

endmodule

bind two_pulse_channel_sound_unit tpcsu_checker u_tpcsu_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int unsigned WAVE_SLOTS    = 1024;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned PHASE_ITEMS   = 88;

   // APB byte address of each register: index times four
   localparam logic [tpcsu_pkg::CSR_ADDR_W-1:0] PERIOD_ADDR =
      {tpcsu_pkg::CSR_SAMPLE_PERIOD, 2'b00};
   localparam logic [tpcsu_pkg::CSR_ADDR_W-1:0] SPARE_CSR_ADDR = 3'd4;

   localparam logic [tpcsu_pkg::PERIOD_W-1:0] DEFAULT_PERIOD = 24'd7346831;
   localparam logic [tpcsu_pkg::PERIOD_W-1:0] ONE_TICK       = 24'h010000;
   localparam logic [2:0]                     STEP_TICKS     = 3'd6;

   // Duty shapes selected by bits 7..6 of a duty write, shape 0 in the low byte
   localparam logic [3:0][7:0] DUTY_SHAPES = {8'hFC, 8'h0F, 8'h03, 8'h01};

   // Tracks the two pulse channels and the decimator, and holds the samples
   // still owed by the block in arrival order.
   class pulse_sample_tracker;
      logic [tpcsu_pkg::PERIOD_W-1:0] period;
      logic [2:0]                     prescale;
      logic [1:0]                     enable;
      logic [7:0]                     duty [2];
      logic [tpcsu_pkg::TIMER_W-1:0]  reload [2];
      logic [tpcsu_pkg::TIMER_W-1:0]  count [2];
      logic [1:0]                     chan_out;
      logic [tpcsu_pkg::ACC_W-1:0]    acc;
      int unsigned                    wave_pos;
      tpcsu_pkg::rsp_item_type        pending_samples [$];
      int unsigned                    mismatch_count;
      int unsigned                    sample_count;
      int unsigned                    wrap_count;

      function new();
         period         = DEFAULT_PERIOD;
         prescale       = '0;
         enable         = '0;
         chan_out       = '0;
         acc            = '0;
         wave_pos       = 0;
         mismatch_count = 0;
         sample_count   = 0;
         wrap_count     = 0;
         for (int ch = 0; ch < 2; ch++) begin
            duty[ch]   = '0;
            reload[ch] = '0;
            count[ch]  = '0;
         end
      endfunction

      function void set_period(input logic [tpcsu_pkg::PERIOD_W-1:0] value);
         period = value;
      endfunction

      // One prescaler step of one channel: count down, or reload and rotate
      function void step_channel(input int ch);
         if (enable[ch]) begin
            if (count[ch] == '0) begin
               count[ch]    = reload[ch];
               duty[ch]     = {duty[ch][0], duty[ch][7:1]};
               chan_out[ch] = duty[ch][0];
            end else begin
               count[ch] = count[ch] - 1'b1;
            end
         end else begin
            chan_out[ch] = 1'b0;
         end
      endfunction

      function void note_item(input logic kind, input logic [15:0] addr,
                              input logic [7:0] value);
         tpcsu_pkg::rsp_item_type owed;
         if (kind == tpcsu_pkg::REQ_WRITE) begin
            case (addr)
               tpcsu_pkg::ADDR_DUTY0:  duty[0]         = DUTY_SHAPES[value[7:6]];
               tpcsu_pkg::ADDR_DUTY1:  duty[1]         = DUTY_SHAPES[value[7:6]];
               tpcsu_pkg::ADDR_TLO0:   reload[0][7:0]  = value;
               tpcsu_pkg::ADDR_TLO1:   reload[1][7:0]  = value;
               tpcsu_pkg::ADDR_THI0:   reload[0][10:8] = value[2:0];
               tpcsu_pkg::ADDR_THI1:   reload[1][10:8] = value[2:0];
               tpcsu_pkg::ADDR_ENABLE: enable          = value[1:0];
               default: ;
            endcase
            return;
         end
         prescale = prescale + 1'b1;
         if (prescale >= STEP_TICKS) begin
            prescale = '0;
            step_channel(0);
            step_channel(1);
         end
         acc = acc - {1'b0, ONE_TICK};
         if (acc == '0 || acc[tpcsu_pkg::ACC_W-1]) begin
            owed.sample_level = {1'b0, chan_out[0]} + {1'b0, chan_out[1]};
            owed.sample_index = wave_pos[tpcsu_pkg::INDEX_W-1:0];
            pending_samples.push_back(owed);
            wave_pos++;
            if (wave_pos >= WAVE_SLOTS) begin
               wave_pos = 0;
               wrap_count++;
            end
            acc = acc + {1'b0, period};
         end
      endfunction

      function void check_sample(input tpcsu_pkg::rsp_item_type seen);
         tpcsu_pkg::rsp_item_type owed;
         sample_count++;
         if (pending_samples.size() == 0) begin
            $error("sample with nothing owed: level %0d index %0d",
                   seen.sample_level, seen.sample_index);
            mismatch_count++;
            return;
         end
         owed = pending_samples.pop_front();
         if (seen.sample_level !== owed.sample_level) begin
            $error("sample_level: expected %0d, got %0d", owed.sample_level,
                   seen.sample_level);
            mismatch_count++;
         end
         if (seen.sample_index !== owed.sample_index) begin
            $error("sample_index: expected %0d, got %0d", owed.sample_index,
                   seen.sample_index);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [tpcsu_pkg::REQ_DATA_W-1:0] req_tdata;   // [15:0] address, [23:16] write_value
   logic                             req_tuser;   // [0] req_type
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [tpcsu_pkg::RSP_DATA_W-1:0] rsp_tdata;   // [1:0] sample_level, [11:2] sample_index
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [tpcsu_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [tpcsu_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [tpcsu_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                             csr_pready;

   pulse_sample_tracker     tracker;
   int unsigned             cycle_count;
   int unsigned             item_count;
   int unsigned             setting_count;
   int unsigned             stall_left;
   bit                      steady;        // set for the closing stretch: no idling
   tpcsu_pkg::rsp_item_type seen_item;

   two_pulse_channel_sound_unit #(.WAVE_DEPTH(WAVE_SLOTS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Hard stop: a hung handshake or a lost sample ends up here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Receiver: now and then stall for a random burst, never in the steady stretch
   always @(negedge clock) begin
      logic ready_next;
      ready_next = 1'b1;
      if (!steady) begin
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            ready_next = 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 4);
            ready_next = 1'b0;
         end
      end
      rsp_tready <= ready_next;
   end

   // Result monitor: compare every accepted sample with the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_item = rsp_tdata[tpcsu_pkg::INDEX_W+1:0];
         tracker.check_sample(seen_item);
      end
   end

   // Present one item, hold it until accepted, then advance the predictor
   task automatic send_item(input logic kind, input logic [15:0] addr,
                            input logic [7:0] value);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {value, addr};
      do @(posedge clock); while (!req_tready);
      tracker.note_item(kind, addr, value);
      item_count++;
   endtask

   task automatic send_ticks(input int unsigned n);
      repeat (n) send_item(tpcsu_pkg::REQ_TICK, 16'($urandom), 8'($urandom));
   endtask

   // Drop valid for a random burst now and then
   task automatic maybe_gap();
      int unsigned gap;
      if (steady || $urandom_range(0, 5) != 0)
         return;
      gap = $urandom_range(1, 5);
      @(negedge clock) req_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clock);
   endtask

   // Mostly ticks; writes favor short timer reloads so the outputs keep moving
   task automatic send_random_item();
      int unsigned pick;
      logic [15:0] addr;
      logic [7:0]  value;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         send_ticks(1);
         return;
      end
      value = 8'($urandom);
      if (pick < 93) begin
         case ($urandom_range(0, 6))
            0: addr = tpcsu_pkg::ADDR_DUTY0;
            1: addr = tpcsu_pkg::ADDR_DUTY1;
            2: addr = tpcsu_pkg::ADDR_TLO0;
            3: addr = tpcsu_pkg::ADDR_TLO1;
            4: addr = tpcsu_pkg::ADDR_THI0;
            5: addr = tpcsu_pkg::ADDR_THI1;
            default: addr = tpcsu_pkg::ADDR_ENABLE;
         endcase
         if ((addr == tpcsu_pkg::ADDR_TLO0 || addr == tpcsu_pkg::ADDR_TLO1)
             && $urandom_range(0, 9) < 7)
            value = 8'($urandom_range(0, 3));
         else if ((addr == tpcsu_pkg::ADDR_THI0 || addr == tpcsu_pkg::ADDR_THI1)
                  && $urandom_range(0, 9) < 8)
            value = value & 8'hF8;
         else if (addr == tpcsu_pkg::ADDR_ENABLE && $urandom_range(0, 9) < 7)
            value = value | 8'h03;
      end else if ($urandom_range(0, 1) == 0) begin
         addr = 16'h4000 | 16'($urandom_range(0, 31));   // near the register map
      end else begin
         addr = 16'($urandom);
      end
      send_item(tpcsu_pkg::REQ_WRITE, addr, value);
   endtask

   // Let every owed sample drain, then give the block spare cycles to settle
   task automatic wait_idle();
      @(negedge clock) req_tvalid <= 1'b0;
      while (tracker.pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [tpcsu_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock) csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == PERIOD_ADDR)
         tracker.set_period(data[tpcsu_pkg::PERIOD_W-1:0]);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_period_readback();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= PERIOD_ADDR;
      @(negedge clock) csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[tpcsu_pkg::PERIOD_W-1:0] !== tracker.period) begin
         $error("sample_period readback: expected %0d, got %0d", tracker.period,
                csr_prdata[tpcsu_pkg::PERIOD_W-1:0]);
         tracker.mismatch_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Idle, load a new sample period, confirm it, then run random items
   task automatic run_phase(input logic [31:0] period_word, input int unsigned n);
      wait_idle();
      csr_write(PERIOD_ADDR, period_word);
      check_period_readback();
      setting_count++;
      repeat (n) begin
         send_random_item();
         maybe_gap();
      end
   endtask

   initial begin
      tracker       = new();
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = tpcsu_pkg::REQ_TICK;
      rsp_tready    = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      cycle_count   = 0;
      item_count    = 0;
      setting_count = 0;
      stall_left    = 0;
      steady        = 1'b0;

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Default period after reset, and a write to an unmapped register index
      check_period_readback();
      csr_write(SPARE_CSR_ADDR, $urandom);
      check_period_readback();

      // Directed part at one sample per tick
      csr_write(PERIOD_ADDR, {8'h00, ONE_TICK});
      setting_count++;
      send_ticks(1);
      send_item(tpcsu_pkg::REQ_WRITE, tpcsu_pkg::ADDR_DUTY0, 8'h00);
      send_item(tpcsu_pkg::REQ_WRITE, tpcsu_pkg::ADDR_DUTY1, 8'hC0);
      // longest reload, then back to zero
      send_item(tpcsu_pkg::REQ_WRITE, tpcsu_pkg::ADDR_TLO0, 8'hFF);
      send_item(tpcsu_pkg::REQ_WRITE, tpcsu_pkg::ADDR_THI0, 8'hFF);
      send_item(tpcsu_pkg::REQ_WRITE, tpcsu_pkg::ADDR_TLO0, 8'h00);
      send_item(tpcsu_pkg::REQ_WRITE, tpcsu_pkg::ADDR_THI0, 8'h00);
      send_item(tpcsu_pkg::REQ_WRITE, tpcsu_pkg::ADDR_TLO1, 8'h01);
      send_item(tpcsu_pkg::REQ_WRITE, tpcsu_pkg::ADDR_THI1, 8'hF8);
      // Writes outside the register map change nothing
      send_item(tpcsu_pkg::REQ_WRITE, 16'h4001, 8'hFF);
      send_item(tpcsu_pkg::REQ_WRITE, 16'h4005, 8'hFF);
      send_item(tpcsu_pkg::REQ_WRITE, 16'hFFFF, 8'hFF);
      send_item(tpcsu_pkg::REQ_WRITE, 16'h0000, 8'h03);
      send_item(tpcsu_pkg::REQ_WRITE, tpcsu_pkg::ADDR_ENABLE, 8'hFF);
      send_ticks(5);                               // first prescaler step
      send_item(tpcsu_pkg::REQ_WRITE, tpcsu_pkg::ADDR_DUTY0, 8'h40);
      send_item(tpcsu_pkg::REQ_WRITE, tpcsu_pkg::ADDR_DUTY1, 8'h80);
      // Disabling keeps the outputs until the next prescaler step
      send_item(tpcsu_pkg::REQ_WRITE, tpcsu_pkg::ADDR_ENABLE, 8'h00);
      send_ticks(6);
      send_item(tpcsu_pkg::REQ_WRITE, tpcsu_pkg::ADDR_ENABLE, 8'h03);

      // Random part across several sample periods, extremes included
      run_phase(32'($urandom_range(32'h10000, 32'h40000)), PHASE_ITEMS);
      run_phase(32'h00018000, PHASE_ITEMS);
      run_phase(32'h00008000, PHASE_ITEMS);        // below one tick per sample
      run_phase(32'h00000000, PHASE_ITEMS);        // accumulator wraps around
      run_phase(32'hA5FFFFFF, PHASE_ITEMS);        // largest period, upper bits ignored

      // Closing stretch without idling at one sample per tick
      wait_idle();
      steady = 1'b1;
      csr_write(PERIOD_ADDR, {8'h00, ONE_TICK});
      check_period_readback();
      setting_count++;
      repeat (PHASE_ITEMS) send_random_item();

      wait_idle();
      repeat (8) @(posedge clock);
      $display("Sent %0d items over %0d sample periods; %0d samples checked.",
               item_count, setting_count, tracker.sample_count);
      $display("Buffer index wrapped %0d time(s); %0d mismatch(es).",
               tracker.wrap_count, tracker.mismatch_count);
      if (tracker.mismatch_count == 0 && tracker.pending_samples.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/tpcsu_pkg.sv
rtl/two_pulse_channel_sound_unit.sv
rtl/tpcsu_checker.sv
sim/tb.sv
